// File: design/spr_pkg.sv
// Shared types, constants and the coil sequence table for the half-step positioner.
package spr_pkg;

    // Motor geometry in half steps; home sits at half a revolution
    localparam int unsigned STEPS_PER_REV = 4096;
    localparam int unsigned HOME_STEPS    = STEPS_PER_REV / 2;
    localparam int unsigned SPR_SHIFT     = $clog2(STEPS_PER_REV);

    // Field widths
    localparam int unsigned POS_W     = 13;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned ANGLE_IN_W = 16;
    localparam int unsigned DELTA_W   = 16;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned COIL_W    = 4;
    localparam int unsigned ANGLE_W   = 9;

    // Degree constants
    localparam int unsigned DEG_PER_REV  = 360;
    localparam int unsigned DEG_HALF     = 180;

    // Angle to target: (a*SPR + 180)/360 == ((a*SPR/8) + 22)/45, the /45 done
    // as a multiply by a rounded-up reciprocal (exact for the whole input range)
    localparam int unsigned TGT_Y_W       = 18;
    localparam int unsigned TGT_RECIP     = 372828;
    localparam int unsigned TGT_RECIP_W   = 19;
    localparam int unsigned TGT_SHIFT     = 24;
    localparam int unsigned TGT_PROD_W    = TGT_Y_W + TGT_RECIP_W;
    localparam int unsigned SPR_DIV8      = STEPS_PER_REV / 8;
    localparam int unsigned HALF_DIV8     = DEG_HALF / 8;

    // Position to degrees: pos*360 + SPR/2
    localparam int unsigned DEG_PROD_W = 21;

    // Relative move sum, signed
    localparam int unsigned REL_W = 18;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_MOVE_ABS = 3'd1,
        CMD_MOVE_REL = 3'd2,
        CMD_STOP     = 3'd3,
        CMD_RESUME   = 3'd4
    } cmd_t;

    // Registered command transaction handed to the core
    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [POS_W-1:0]          angle_target;
        logic signed [DELTA_W-1:0] step_delta;
    } cmd_item_t;

    // Eight-phase half-step coil sequence, bit0 IN1 .. bit3 IN4
    function automatic logic [COIL_W-1:0] coil_seq(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        unique case (phase)
            3'd0:    pat = 4'd1;
            3'd1:    pat = 4'd9;
            3'd2:    pat = 4'd8;
            3'd3:    pat = 4'd12;
            3'd4:    pat = 4'd4;
            3'd5:    pat = 4'd6;
            3'd6:    pat = 4'd2;
            default: pat = 4'd3;
        endcase
        return pat;
    endfunction

endpackage

// File: design/stepper_half_step_positioner.sv
// Top level of the half-step stepper positioner.
//
// Command channel (cmd_valid/cmd_ready) carries command, target_angle and
// step_delta; each transaction gives exactly one status transaction on the
// status channel (status_valid/status_ready) with coil_pattern, stepped,
// position, angle_deg and idle.
// Commands: tick steps one half step toward the target, move to angle and
// move relative set the target, stop and resume switch the coils.
// The input register captures a command at the edge that accepts it, and the
// execution logic then loads the result register from it, so status_valid
// rises once a command has passed both registers. Throughput is one
// transaction per cycle while the receiver takes each status transaction,
// with the position state in the core updated as each command executes.
// The input register takes a new command while a status transaction waits;
// when the receiver stalls, at most one further command is held before
// cmd_ready drops. Status payload holds steady until taken.
// Reset (rst_n low, asynchronous) returns position and target to half a
// revolution, phase to zero and the coils to energized, and empties both
// stages.
module stepper_half_step_positioner
    import spr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  logic [CMD_W-1:0]          command,
    input  logic [ANGLE_IN_W-1:0]     target_angle,
    input  logic signed [DELTA_W-1:0] step_delta,
    output logic                      status_valid,
    input  logic                      status_ready,
    output logic [COIL_W-1:0]         coil_pattern,
    output logic                      stepped,
    output logic [POS_W-1:0]          position,
    output logic [ANGLE_W-1:0]        angle_deg,
    output logic                      idle
);

    logic      item_valid;
    cmd_item_t item;
    logic      item_take;

    spr_cmd_stage u_cmd_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .command      (command),
        .target_angle (target_angle),
        .step_delta   (step_delta),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take)
    );

    spr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take),
        .status_valid (status_valid),
        .status_ready (status_ready),
        .coil_pattern (coil_pattern),
        .stepped      (stepped),
        .position     (position),
        .angle_deg    (angle_deg),
        .idle         (idle)
    );

endmodule

// File: design/spr_cmd_stage.sv
// Input register: captures a command transaction and converts the angle to a target.
module spr_cmd_stage
    import spr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  logic [CMD_W-1:0]          command,
    input  logic [ANGLE_IN_W-1:0]     target_angle,
    input  logic signed [DELTA_W-1:0] step_delta,
    output logic                      item_valid,
    output cmd_item_t                 item,
    input  logic                      item_take
);

    logic                  item_valid_reg;
    logic                  item_valid_next;
    cmd_item_t             item_reg;
    logic [ANGLE_W-1:0]    ang_clamped;
    logic [TGT_Y_W-1:0]    tgt_y;
    logic [TGT_PROD_W-1:0] tgt_prod;
    logic [POS_W-1:0]      tgt_steps;
    logic                  load;

    // Clamp to a full turn, then scale by the reciprocal of 45
    always_comb
    begin
        if (target_angle > ANGLE_IN_W'(DEG_PER_REV))
            ang_clamped = ANGLE_W'(DEG_PER_REV);
        else
            ang_clamped = target_angle[ANGLE_W-1:0];
        tgt_y     = TGT_Y_W'(ang_clamped) * TGT_Y_W'(SPR_DIV8) + TGT_Y_W'(HALF_DIV8);
        tgt_prod  = TGT_PROD_W'(tgt_y) * TGT_PROD_W'(TGT_RECIP);
        tgt_steps = tgt_prod[TGT_SHIFT +: POS_W];
    end

    // Stage accepts when empty or when the core drains it this cycle
    assign cmd_ready       = !item_valid_reg || item_take;
    assign load            = cmd_valid && cmd_ready;
    assign item_valid_next = load ? 1'b1 : (item_take ? 1'b0 : item_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.command      <= command;
            item_reg.angle_target <= tgt_steps;
            item_reg.step_delta   <= step_delta;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// File: design/spr_core.sv
// Positioner state, command execution and the status result register.
module spr_core
    import spr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  cmd_item_t          item,
    output logic               item_take,
    output logic               status_valid,
    input  logic               status_ready,
    output logic [COIL_W-1:0]  coil_pattern,
    output logic               stepped,
    output logic [POS_W-1:0]   position,
    output logic [ANGLE_W-1:0] angle_deg,
    output logic               idle
);

    logic [POS_W-1:0]      position_reg,  position_next;
    logic [POS_W-1:0]      target_reg,    target_next;
    logic [PHASE_W-1:0]    phase_reg,     phase_next;
    logic                  coils_on_reg,  coils_on_next;
    logic                  status_valid_reg, status_valid_next;
    logic [COIL_W-1:0]     coil_pattern_reg, coil_pattern_next;
    logic                  stepped_reg,   stepped_next;
    logic [POS_W-1:0]      position_out_reg;
    logic [ANGLE_W-1:0]    angle_deg_reg, angle_deg_next;
    logic                  idle_reg,      idle_next;

    logic                  load;
    logic signed [REL_W-1:0] rel_sum;
    logic [POS_W-1:0]      rel_target;
    logic [POS_W-1:0]      new_target;
    logic                  set_target;
    logic [DEG_PROD_W-1:0] deg_scaled;

    // Result slot free or being emptied: execute the pending transaction
    assign load      = item_valid && (!status_valid_reg || status_ready);
    assign item_take = load;

    // Relative target, saturated to one revolution
    always_comb
    begin
        rel_sum = REL_W'($signed({1'b0, position_reg})) + REL_W'(item.step_delta);
        if (rel_sum < $signed(REL_W'(0)))
            rel_target = '0;
        else if (rel_sum > $signed(REL_W'(STEPS_PER_REV)))
            rel_target = POS_W'(STEPS_PER_REV);
        else
            rel_target = rel_sum[POS_W-1:0];
    end

    // Command decode and next state
    always_comb
    begin
        position_next = position_reg;
        target_next   = target_reg;
        phase_next    = phase_reg;
        coils_on_next = coils_on_reg;
        stepped_next  = 1'b0;
        new_target    = item.angle_target;
        set_target    = 1'b0;
        unique case (item.command)
            CMD_TICK:
            begin
                if (position_reg != target_reg)
                begin
                    if (position_reg < target_reg)
                    begin
                        if (position_reg < POS_W'(STEPS_PER_REV))
                        begin
                            phase_next    = phase_reg + PHASE_W'(1);
                            position_next = position_reg + POS_W'(1);
                        end
                    end
                    else if (position_reg != '0)
                    begin
                        phase_next    = phase_reg - PHASE_W'(1);
                        position_next = position_reg - POS_W'(1);
                    end
                    coils_on_next = 1'b1;
                    stepped_next  = 1'b1;
                end
            end
            CMD_MOVE_ABS:
            begin
                new_target = item.angle_target;
                set_target = 1'b1;
            end
            CMD_MOVE_REL:
            begin
                new_target = rel_target;
                set_target = 1'b1;
            end
            CMD_STOP:   coils_on_next = 1'b0;
            CMD_RESUME: coils_on_next = 1'b1;
            default:    ;
        endcase
        // A move onto the current position keeps any move in progress
        if (set_target && (new_target != position_reg))
            target_next = new_target;
    end

    // Status fields from the updated state
    always_comb
    begin
        coil_pattern_next = coils_on_next ? coil_seq(phase_next) : '0;
        deg_scaled = DEG_PROD_W'(position_next) * DEG_PROD_W'(DEG_PER_REV)
                   + DEG_PROD_W'(HOME_STEPS);
        angle_deg_next = deg_scaled[SPR_SHIFT +: ANGLE_W];
        idle_next      = (position_next == target_next);
        if (load)
            status_valid_next = 1'b1;
        else if (status_ready)
            status_valid_next = 1'b0;
        else
            status_valid_next = status_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= POS_W'(HOME_STEPS);
            target_reg       <= POS_W'(HOME_STEPS);
            phase_reg        <= '0;
            coils_on_reg     <= 1'b1;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            status_valid_reg <= status_valid_next;
            if (load)
            begin
                position_reg <= position_next;
                target_reg   <= target_next;
                phase_reg    <= phase_next;
                coils_on_reg <= coils_on_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            coil_pattern_reg <= coil_pattern_next;
            stepped_reg      <= stepped_next;
            position_out_reg <= position_next;
            angle_deg_reg    <= angle_deg_next;
            idle_reg         <= idle_next;
        end
    end

    assign status_valid = status_valid_reg;
    assign coil_pattern = coil_pattern_reg;
    assign stepped      = stepped_reg;
    assign position     = position_out_reg;
    assign angle_deg    = angle_deg_reg;
    assign idle         = idle_reg;

    // Position and target never leave one revolution
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (position_reg <= POS_W'(STEPS_PER_REV)) && (target_reg <= POS_W'(STEPS_PER_REV)))
        else $error("position or target beyond one revolution");

    // At most one half step per cycle
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (position_reg == $past(position_reg))
              || (position_reg == $past(position_reg) + POS_W'(1))
              || (position_reg == $past(position_reg) - POS_W'(1)))
        else $error("position jumped by more than one half step");

    // A stepping tick really moves the rotor
    a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (load && stepped_next) |=> (position_reg != $past(position_reg)))
        else $error("tick reported a step without moving");

    // Pending result agrees with the state it reports
    a_idle_match: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid_reg |-> (idle_reg == (position_reg == target_reg))
                          && (position_out_reg == position_reg))
        else $error("status result out of step with state");

    // Coils off means no drive
    a_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
        (status_valid_reg && !coils_on_reg) |-> (coil_pattern_reg == '0))
        else $error("coil drive while stopped");

endmodule
